// ----- sv/mat4_column_transform_defines.svh -----
// Assertion macros for the mat4_column_transform block.
// Used by the top level; no other dependencies.
`ifndef MAT4_COLUMN_TRANSFORM_DEFINES_SVH
`define MAT4_COLUMN_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define M4CT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define M4CT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define M4CT_ASSERT_NOW(label, ante, cons)
`define M4CT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/m4ct_pkg.sv -----
// Shared types and constants for the 4x4 column transform block.
// No dependencies.
package m4ct_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT = 16;
  localparam int unsigned DIM               = 4;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned PROD_W            = 2 * WORD_W;
  localparam int unsigned PAIR_W            = PROD_W + 1;
  localparam int unsigned SUM_W             = PROD_W + 2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_row0;
    logic signed [31:0] out_row1;
    logic signed [31:0] out_row2;
    logic signed [31:0] out_row3;
    logic               saturated;
  } res_t;

  // Load enables for the three lane stages.
  typedef struct packed {
    logic prod_load;
    logic pair_load;
    logic sum_load;
  } adv_t;

endpackage

// ----- sv/m4ct_row_dot.sv -----
// One row lane: four products, pairwise sums, full sum, each registered.
// Depends on m4ct_pkg.
module m4ct_row_dot (
  input  logic                                             clk,
  input  m4ct_pkg::adv_t                                   adv,
  input  logic [m4ct_pkg::DIM-1:0][m4ct_pkg::WORD_W-1:0]   coef,
  input  logic [m4ct_pkg::DIM-1:0][m4ct_pkg::WORD_W-1:0]   vec,
  output logic signed [m4ct_pkg::SUM_W-1:0]                sum
);

  logic signed [m4ct_pkg::PROD_W-1:0] prod [m4ct_pkg::DIM];
  logic signed [m4ct_pkg::PAIR_W-1:0] pair [2];

  // Products of signed words are exact in 64 bits.
  always_ff @(posedge clk) begin
    if (adv.prod_load) begin
      for (int k = 0; k < m4ct_pkg::DIM; k++) begin
        prod[k] <= $signed(coef[k]) * $signed(vec[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.pair_load) begin
      pair[0] <= {prod[0][m4ct_pkg::PROD_W-1], prod[0]} + {prod[1][m4ct_pkg::PROD_W-1], prod[1]};
      pair[1] <= {prod[2][m4ct_pkg::PROD_W-1], prod[2]} + {prod[3][m4ct_pkg::PROD_W-1], prod[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum_load) begin
      sum <= {pair[0][m4ct_pkg::PAIR_W-1], pair[0]} + {pair[1][m4ct_pkg::PAIR_W-1], pair[1]};
    end
  end

endmodule

// ----- sv/mat4_column_transform.sv -----
// mat4_column_transform: an accepted transform item passes the stages below to its result.
// Throughput one item per cycle while cmd_stall is low; load items give no result.
// Stages: multiply, pair add, row add, shift and saturate into the output register.
// Reset (rst, synchronous) clears all stage valid bits and the left matrix to zero.
// A stalled result holds only the stages behind it that are full; bubbles collapse.
`include "mat4_column_transform_defines.svh"

module mat4_column_transform #(
  parameter int unsigned FRAC_BITS = m4ct_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  m4ct_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output m4ct_pkg::res_t res
);

  localparam int unsigned DIM   = m4ct_pkg::DIM;
  localparam int unsigned W     = m4ct_pkg::WORD_W;
  localparam int unsigned SUM_W = m4ct_pkg::SUM_W;

  // Left matrix, column-major: element column*4 + row.
  logic [W-1:0] left_matrix [DIM*DIM];

  // Stage valid bits: products, pair sums, row sums; res_valid is the output stage.
  logic prod_valid;
  logic pair_valid;
  logic sum_valid;

  logic out_free;
  logic sum_free;
  logic pair_free;
  logic prod_free;
  logic cmd_accept;

  m4ct_pkg::adv_t adv;

  logic [DIM-1:0][W-1:0]          vec;
  logic [DIM-1:0][DIM-1:0][W-1:0] coef;
  logic signed [SUM_W-1:0]        row_sum [DIM];
  logic signed [SUM_W-1:0]        row_shift [DIM];
  logic [DIM-1:0][W-1:0]          row_sat;
  logic [DIM-1:0]                 row_clip;

  // A stage may load when it is empty or its content moves on this edge.
  assign out_free   = !res_valid || !res_stall;
  assign sum_free   = !sum_valid || out_free;
  assign pair_free  = !pair_valid || sum_free;
  assign prod_free  = !prod_valid || pair_free;
  assign cmd_stall  = !prod_free;
  assign cmd_accept = cmd_valid && !cmd_stall;

  assign adv.prod_load = prod_free;
  assign adv.pair_load = pair_free;
  assign adv.sum_load  = sum_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= cmd_accept && (cmd.mode == m4ct_pkg::MODE_XFORM);
      end
      if (pair_free) begin
        pair_valid <= prod_valid;
      end
      if (sum_free) begin
        sum_valid <= pair_valid;
      end
      if (out_free) begin
        res_valid <= sum_valid;
      end
    end
  end

  // Apply a load item at acceptance; a transform item already read the matrix
  // into its products on its own acceptance edge, so order is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIM*DIM; i++) begin
        left_matrix[i] <= '0;
      end
    end else if (cmd_accept && (cmd.mode == m4ct_pkg::MODE_LOAD)) begin
      left_matrix[cmd.elem_index] <= cmd.elem_value;
    end
  end

  assign vec[0] = cmd.vec_x;
  assign vec[1] = cmd.vec_y;
  assign vec[2] = cmd.vec_z;
  assign vec[3] = cmd.vec_w;

  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar k = 0; k < DIM; k++) begin : g_col
      assign coef[r][k] = left_matrix[k*DIM + r];
    end

    m4ct_row_dot u_row (
      .clk  (clk),
      .adv  (adv),
      .coef (coef[r]),
      .vec  (vec),
      .sum  (row_sum[r])
    );

    // Floor shift, then clip when the sign bit of a 32-bit word and the bits above it disagree.
    assign row_shift[r] = row_sum[r] >>> FRAC_BITS;
    assign row_clip[r]  = !((&row_shift[r][SUM_W-1:W-1]) || !(|row_shift[r][SUM_W-1:W-1]));
    assign row_sat[r]   = !row_clip[r] ? row_shift[r][W-1:0] :
                          row_shift[r][SUM_W-1] ? {1'b1, {(W-1){1'b0}}} :
                                                  {1'b0, {(W-1){1'b1}}};
  end

  // Output register: holds while the result is stalled.
  always_ff @(posedge clk) begin
    if (out_free) begin
      res.out_row0  <= row_sat[0];
      res.out_row1  <= row_sat[1];
      res.out_row2  <= row_sat[2];
      res.out_row3  <= row_sat[3];
      res.saturated <= |row_clip;
    end
  end

  // An accepted transform item always lands in the product stage.
  `M4CT_ASSERT_NEXT(a_xform_enters, cmd_valid && !cmd_stall && cmd.mode == m4ct_pkg::MODE_XFORM, prod_valid)
  // Input is held back only while every stage, the product stage included, is occupied.
  `M4CT_ASSERT_NOW(a_stall_needs_full, cmd_stall, prod_valid && pair_valid && sum_valid && res_valid)
  // A clipped result shows at least one limit value.
  `M4CT_ASSERT_NOW(a_sat_limits, res_valid && res.saturated, res.out_row0 == 32'sh7fffffff || res.out_row0 == 32'sh80000000 || res.out_row1 == 32'sh7fffffff || res.out_row1 == 32'sh80000000 || res.out_row2 == 32'sh7fffffff || res.out_row2 == 32'sh80000000 || res.out_row3 == 32'sh7fffffff || res.out_row3 == 32'sh80000000)

endmodule

// ----- sim/mat4_column_transform_test.sv -----
// Self-checking testbench for mat4_column_transform: a directed stimulus table, then random
// load and transform items, both handshakes idled at random. Depends on m4ct_pkg and the RTL.
`timescale 1ns / 100ps

module mat4_column_transform_test;

  localparam int unsigned FRAC          = m4ct_pkg::FRAC_BITS_DEFAULT;
  localparam int          N_DIRECTED    = 23;
  localparam int          RANDOM_ITEMS  = 1100;
  localparam int          CALM_TAIL     = 150;   // last random items run with no idling
  localparam int          HOLD_AT_ITEM  = 300;
  localparam int          HOLD_CYCLES   = 120;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          CYCLE_LIMIT   = 200000;

  localparam logic signed [65:0] WORD_MAX = 66'sd2147483647;
  localparam logic signed [65:0] WORD_MIN = -66'sd2147483648;

  // One directed row: the item, and the column to expect when it is obvious.
  typedef struct packed {
    logic        mode;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        typed;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    logic        sat;
  } stim_row_t;

  // Untyped rows carry zeros in the expected columns; the predictor decides those.
  stim_row_t directed_rows [N_DIRECTED] = '{
    // Matrix is all zero after reset, so any column gives zeros.
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
      1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    // Load the identity (1.0 on the diagonal); vec fields on a load are ignored.
    '{m4ct_pkg::MODE_LOAD, 4'd0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_LOAD, 4'd5, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_LOAD, 4'd10, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_LOAD, 4'd15, 32'h00010000,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    // Identity passes the column through, extremes included; elem fields ignored.
    '{m4ct_pkg::MODE_XFORM, 4'd15, 32'hFFFFFFFF,
      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00000001,
      1'b1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00000001, 1'b0},
    // Max times max clips high, max times min clips low.
    '{m4ct_pkg::MODE_LOAD, 4'd0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 1'b1},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b1},
    // Min times min is the largest single product.
    '{m4ct_pkg::MODE_LOAD, 4'd0, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 1'b1},
    // Smallest step: floor rounding takes a product of -1/2^32 down to -1/65536 and 1/2^32 down to 0.
    '{m4ct_pkg::MODE_LOAD, 4'd0, 32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0,
      1'b1, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'h00000001, 32'h0, 32'h0, 32'h0,
      1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    // Off-diagonal corners of the matrix.
    '{m4ct_pkg::MODE_LOAD, 4'd3, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_LOAD, 4'd12, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'h80000000,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    // Three min*min products in one row overflow 64 bits before the shift.
    '{m4ct_pkg::MODE_LOAD, 4'd4, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_LOAD, 4'd8, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0,
      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd6, 32'h1234ABCD,
      32'h00018000, 32'hFFFE4000, 32'h7FFF0000, 32'h80010000,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_LOAD, 4'd15, 32'hFFFF0000, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{m4ct_pkg::MODE_XFORM, 4'd0, 32'h0,
      32'h00030000, 32'hFFFD0000, 32'h00008000, 32'h00024000,
      1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  m4ct_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  m4ct_pkg::res_t res;

  // Travel with cmd: a hand-typed expectation for the item on offer.
  logic typed_valid = 1'b0;
  m4ct_pkg::res_t typed_res = '0;

  logic [31:0]    left_words [16] = '{default: 32'h0};
  m4ct_pkg::res_t expected_columns [$];
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             gaps_on = 1'b1;
  bit             hold_off = 1'b0;

  mat4_column_transform #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Column of the product: each row sums four exact products in 66 bits,
  // floors by the fraction bits and clamps to a signed word.
  function automatic m4ct_pkg::res_t column_product(m4ct_pkg::cmd_t c);
    logic [31:0]        vec [4];
    logic [31:0]        lane [4];
    logic signed [65:0] acc;
    logic signed [65:0] lhs;
    logic signed [65:0] rhs;
    logic signed [65:0] shifted;
    logic               clipped;
    int                 row;
    int                 k;
    vec[0]  = c.vec_x;
    vec[1]  = c.vec_y;
    vec[2]  = c.vec_z;
    vec[3]  = c.vec_w;
    clipped = 1'b0;
    for (row = 0; row < 4; row++) begin
      acc = '0;
      for (k = 0; k < 4; k++) begin
        lhs = {{34{left_words[k*4+row][31]}}, left_words[k*4+row]};
        rhs = {{34{vec[k][31]}}, vec[k]};
        acc = acc + lhs * rhs;
      end
      shifted = acc >>> FRAC;
      if (shifted > WORD_MAX) begin
        lane[row] = 32'h7FFFFFFF;
        clipped   = 1'b1;
      end else if (shifted < WORD_MIN) begin
        lane[row] = 32'h80000000;
        clipped   = 1'b1;
      end else begin
        lane[row] = shifted[31:0];
      end
    end
    return m4ct_pkg::res_t'{lane[0], lane[1], lane[2], lane[3], clipped};
  endfunction

  // Mostly small Q16.16 values (within +-4.0) so rows stay in range, with
  // corners and full-width words mixed in to reach saturation.
  function automatic logic [31:0] fixed_word();
    logic [31:0] corners [6] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF,
                                 32'h00010000, 32'hFFFF0000};
    case ($urandom_range(0, 15))
      0:       return corners[$urandom_range(0, 5)];
      1:       return $urandom();
      default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    endcase
  endfunction

  function automatic m4ct_pkg::cmd_t random_item();
    m4ct_pkg::cmd_t c;
    c.mode       = ($urandom_range(0, 99) < 35) ? m4ct_pkg::MODE_LOAD : m4ct_pkg::MODE_XFORM;
    c.elem_index = 4'($urandom_range(0, 15));
    c.elem_value = fixed_word();
    c.vec_x      = fixed_word();
    c.vec_y      = fixed_word();
    c.vec_z      = fixed_word();
    c.vec_w      = fixed_word();
    return c;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_column(m4ct_pkg::res_t got);
    m4ct_pkg::res_t want;
    if (expected_columns.size() == 0) begin
      note_mismatch($sformatf("result %h with nothing expected", got));
    end else begin
      want = expected_columns.pop_front();
      if (got.out_row0 !== want.out_row0)
        note_mismatch($sformatf("out_row0 expected %h got %h", want.out_row0, got.out_row0));
      if (got.out_row1 !== want.out_row1)
        note_mismatch($sformatf("out_row1 expected %h got %h", want.out_row1, got.out_row1));
      if (got.out_row2 !== want.out_row2)
        note_mismatch($sformatf("out_row2 expected %h got %h", want.out_row2, got.out_row2));
      if (got.out_row3 !== want.out_row3)
        note_mismatch($sformatf("out_row3 expected %h got %h", want.out_row3, got.out_row3));
      if (got.saturated !== want.saturated)
        note_mismatch($sformatf("saturated expected %b got %b", want.saturated, got.saturated));
    end
  endtask

  // Watch both handshakes at each edge: check the result first, then log the
  // accepted item, so a stray result can never pair with the item just taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall)
        check_column(res);
      if (cmd_valid && !cmd_stall) begin
        if (cmd.mode == m4ct_pkg::MODE_LOAD)
          left_words[cmd.elem_index] = cmd.elem_value;
        else
          expected_columns.push_back(typed_valid ? typed_res : column_product(cmd));
      end
    end
  end

  // Hard stop for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mat4_column_transform_test: done, errors");
      $finish;
    end
  end

  // Offer one item and hold it until taken; drop valid first for a random gap.
  // Never idle during the long hold, so the pipe fills and stalls its input.
  task automatic offer_item(m4ct_pkg::cmd_t c, logic typed, m4ct_pkg::res_t want);
    if (gaps_on && !hold_off && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cmd         <= c;
    cmd_valid   <= 1'b1;
    typed_valid <= typed;
    typed_res   <= want;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Receiver: random stall bursts while idling is on, plus one long hold.
  initial begin
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off  = 1'b0;
        res_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // Sender: reset, directed table, random items, then drain and report.
  initial begin
    stim_row_t row;
    int        i;
    int        n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      offer_item(m4ct_pkg::cmd_t'{row.mode, row.idx, row.val, row.x, row.y, row.z, row.w},
                 row.typed,
                 m4ct_pkg::res_t'{row.r0, row.r1, row.r2, row.r3, row.sat});
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch idling on and off in stretches; keep it off at the end.
      if (n >= RANDOM_ITEMS - CALM_TAIL)
        gaps_on = 1'b0;
      else if (n % 100 == 0)
        gaps_on = ($urandom_range(0, 3) != 0);
      if (n == HOLD_AT_ITEM)
        hold_off = 1'b1;
      offer_item(random_item(), 1'b0, '0);
    end
    cmd_valid   <= 1'b0;
    typed_valid <= 1'b0;

    while (expected_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("mat4_column_transform_test: done, clean");
    else
      $display("mat4_column_transform_test: done, errors");
    $finish;
  end

endmodule
